[src/camera_frame_receiver_crc8_top_assert.svh]
// Assertion macros shared by the checker of the frame receiver.
// Each macro places one labeled concurrent assertion, clocked on the rising
// edge and disabled while reset is high.
`ifndef CAMERA_FRAME_RECEIVER_CRC8_TOP_ASSERT_SVH
`define CAMERA_FRAME_RECEIVER_CRC8_TOP_ASSERT_SVH

// Same-cycle implication: when cond_a holds, cond_b must hold in that cycle.
`define CFRC8_ASSERT_SAME(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond_a) |-> (cond_b)) else $error("frame receiver check failed");

// Next-cycle implication: when cond_a holds, cond_b must hold in the next cycle.
`define CFRC8_ASSERT_NEXT(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond_a) |=> (cond_b)) else $error("frame receiver check failed");

`endif

[src/cfrc8_pkg.sv]
package cfrc8_pkg;

   // Framing and check constants.
   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] CRC_POLY   = 8'h31;
   localparam logic [7:0] CRC_INIT   = 8'hFF;
   localparam int         PAYLOAD_LEN = 4;
   localparam int         STORE_IDX_W = $clog2(PAYLOAD_LEN);

   // Frame phase codes.
   localparam logic [2:0] PHASE_HUNT  = 3'd0;
   localparam logic [2:0] PHASE_PAY0  = 3'd1;
   localparam logic [2:0] PHASE_PAY3  = 3'd4;
   localparam logic [2:0] PHASE_CHECK = 3'd5;

   // Angle wrap limits in degrees.
   localparam logic [9:0] ANGLE_HALF = 10'd180;
   localparam logic [9:0] ANGLE_FULL = 10'd360;

   typedef logic [7:0]        byte_type;
   typedef logic signed [8:0] angle_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic byte_type crc8_step(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Twice the byte, folded into -179..180 by one subtraction of 360.
   function automatic angle_type wrap_angle(input byte_type b);
      logic [9:0] v;
      v = {1'b0, b, 1'b0};
      if (v > ANGLE_HALF) begin
         v = v - ANGLE_FULL;
      end
      return $signed(v[8:0]);
   endfunction

endpackage

[src/camera_frame_receiver_crc8_top.sv]
// Framed packet receiver with a CRC-8 check (polynomial 0x31, start 0xFF).
// Request channel: one received byte per request on req_rx_byte, handshake
// req_valid / req_stall. Bytes other than 0xFF are dropped while hunting for
// a start byte; after it come four payload bytes and one check byte.
// Response channel: one response per check byte, handshake rsp_valid /
// rsp_stall. rsp_frame_ok tells whether the check byte matched; the distance
// and angle outputs carry the held values, updated only on a match.
// A check byte passes through the input register, then the response register.
// Throughput: one byte per cycle unless a check byte is held by a stall;
// the CRC step and phase update for a byte fit in the single logic stage between
// the two registers.
// Reset (synchronous, active high) returns the receiver to hunting, sets
// the CRC to its initial value and clears the held values to zero.
// When the receiver stalls the response channel, the pending response holds;
// payload bytes keep flowing, and a following check byte waits in the input
// register, which then raises req_stall until the response is taken.
module camera_frame_receiver_crc8_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cfrc8_pkg::byte_type  req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_frame_ok,
   output cfrc8_pkg::byte_type  rsp_dist_blue,
   output cfrc8_pkg::angle_type rsp_angle_blue,
   output cfrc8_pkg::byte_type  rsp_dist_yellow,
   output cfrc8_pkg::angle_type rsp_angle_yellow
);
   import cfrc8_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   byte_type               in_byte_ff, in_byte_in;
   logic [2:0]             phase_ff, phase_in;
   byte_type               crc_ff, crc_in;
   byte_type               store_ff [PAYLOAD_LEN];
   byte_type               held_dist_blue_ff, held_dist_blue_in;
   angle_type              held_angle_blue_ff, held_angle_blue_in;
   byte_type               held_dist_yellow_ff, held_dist_yellow_in;
   angle_type              held_angle_yellow_ff, held_angle_yellow_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_frame_ok_ff, rsp_frame_ok_in;
   byte_type               rsp_dist_blue_ff, rsp_dist_blue_in;
   angle_type              rsp_angle_blue_ff, rsp_angle_blue_in;
   byte_type               rsp_dist_yellow_ff, rsp_dist_yellow_in;
   angle_type              rsp_angle_yellow_ff, rsp_angle_yellow_in;

   logic                   out_free;
   logic                   is_payload;
   logic                   is_check;
   logic                   proc_go;
   logic                   emit;
   logic                   match;
   logic [2:0]             phase_off;
   logic [STORE_IDX_W-1:0] store_idx;

   // Phase decode and the stage-advance condition.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_payload = (phase_ff >= PHASE_PAY0) && (phase_ff <= PHASE_PAY3);
   assign is_check   = (phase_ff == PHASE_CHECK);
   assign proc_go    = in_valid_ff && (!is_check || out_free);
   assign emit       = proc_go && is_check;
   assign match      = (in_byte_ff == crc_ff);
   assign phase_off  = phase_ff - PHASE_PAY0;
   assign store_idx  = phase_off[STORE_IDX_W-1:0];
   assign req_stall  = in_valid_ff && !proc_go;

   // Input register takes a new request whenever it is empty or moving on.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
   end

   // Phase and running CRC.
   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      if (proc_go) begin
         priority if (is_payload) begin
            phase_in = phase_ff + 3'd1;
            crc_in   = crc8_step(crc_ff, in_byte_ff);
         end else if (is_check) begin
            phase_in = PHASE_HUNT;
            crc_in   = CRC_INIT;
         end else if (in_byte_ff == START_BYTE) begin
            phase_in = PHASE_PAY0;
            crc_in   = CRC_INIT;
         end else begin
            phase_in = PHASE_HUNT;
         end
      end
   end

   // Held values change only on a matching check byte.
   always_comb begin
      held_dist_blue_in    = held_dist_blue_ff;
      held_angle_blue_in   = held_angle_blue_ff;
      held_dist_yellow_in  = held_dist_yellow_ff;
      held_angle_yellow_in = held_angle_yellow_ff;
      if (emit && match) begin
         held_dist_blue_in    = store_ff[0];
         held_angle_blue_in   = wrap_angle(store_ff[1]);
         held_dist_yellow_in  = store_ff[2];
         held_angle_yellow_in = wrap_angle(store_ff[3]);
      end
   end

   // Response register: loaded on a check byte, cleared once taken.
   always_comb begin
      rsp_valid_in        = rsp_valid_ff && !out_free;
      rsp_frame_ok_in     = rsp_frame_ok_ff;
      rsp_dist_blue_in    = rsp_dist_blue_ff;
      rsp_angle_blue_in   = rsp_angle_blue_ff;
      rsp_dist_yellow_in  = rsp_dist_yellow_ff;
      rsp_angle_yellow_in = rsp_angle_yellow_ff;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_frame_ok_in     = match;
         rsp_dist_blue_in    = held_dist_blue_in;
         rsp_angle_blue_in   = held_angle_blue_in;
         rsp_dist_yellow_in  = held_dist_yellow_in;
         rsp_angle_yellow_in = held_angle_yellow_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         phase_ff             <= PHASE_HUNT;
         crc_ff               <= CRC_INIT;
         held_dist_blue_ff    <= '0;
         held_angle_blue_ff   <= '0;
         held_dist_yellow_ff  <= '0;
         held_angle_yellow_ff <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         in_valid_ff          <= in_valid_in;
         phase_ff             <= phase_in;
         crc_ff               <= crc_in;
         held_dist_blue_ff    <= held_dist_blue_in;
         held_angle_blue_ff   <= held_angle_blue_in;
         held_dist_yellow_ff  <= held_dist_yellow_in;
         held_angle_yellow_ff <= held_angle_yellow_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff          <= in_byte_in;
      rsp_frame_ok_ff     <= rsp_frame_ok_in;
      rsp_dist_blue_ff    <= rsp_dist_blue_in;
      rsp_angle_blue_ff   <= rsp_angle_blue_in;
      rsp_dist_yellow_ff  <= rsp_dist_yellow_in;
      rsp_angle_yellow_ff <= rsp_angle_yellow_in;
      if (proc_go && is_payload) begin
         store_ff[store_idx] <= in_byte_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ok     = rsp_frame_ok_ff;
   assign rsp_dist_blue    = rsp_dist_blue_ff;
   assign rsp_angle_blue   = rsp_angle_blue_ff;
   assign rsp_dist_yellow  = rsp_dist_yellow_ff;
   assign rsp_angle_yellow = rsp_angle_yellow_ff;

endmodule

[src/cfrc8_checker.sv]
`include "camera_frame_receiver_crc8_top_assert.svh"

module cfrc8_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_frame_ok,
   input cfrc8_pkg::byte_type  rsp_dist_blue,
   input cfrc8_pkg::angle_type rsp_angle_blue,
   input cfrc8_pkg::byte_type  rsp_dist_yellow,
   input cfrc8_pkg::angle_type rsp_angle_yellow
);
   import cfrc8_pkg::*;

   logic        angles_in_range;
   logic [34:0] rsp_payload;

   // Both reported angles lie in -180..180.
   assign angles_in_range = (rsp_angle_blue >= -9'sd180) && (rsp_angle_blue <= 9'sd180) &&
                            (rsp_angle_yellow >= -9'sd180) && (rsp_angle_yellow <= 9'sd180);

   // All response fields side by side.
   assign rsp_payload = {rsp_frame_ok, rsp_dist_blue, rsp_angle_blue,
                         rsp_dist_yellow, rsp_angle_yellow};

   // A stalled response stays offered.
   `CFRC8_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid)

   // A stalled response keeps its fields.
   `CFRC8_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && rsp_stall, $stable(rsp_payload))

   // No response is pending right after reset.
   `CFRC8_ASSERT_SAME(a_rsp_idle_after_reset, $past(reset), !rsp_valid)

   // Every response carries angles inside the wrap range.
   `CFRC8_ASSERT_SAME(a_angle_range, rsp_valid, angles_in_range)

   // Requests are only held back while a response waits on a stalled receiver.
   `CFRC8_ASSERT_SAME(a_req_stall_cause, req_stall, rsp_valid && rsp_stall)

endmodule

bind camera_frame_receiver_crc8_top cfrc8_checker u_cfrc8_checker (.*);

[tb/camera_frame_receiver_crc8_top_test.sv]
`timescale 1ns / 1ps

module camera_frame_receiver_crc8_top_test;
   import cfrc8_pkg::*;

   // Cycles without any handshake before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   // Cycles allowed after the last response for the pipeline to drain.
   localparam int DRAIN_CYCLES = 6;
   // Frame bytes sent by the random part; the tail runs without idling.
   localparam int RANDOM_BYTES = 830;
   localparam int QUIET_FROM = 700;

   typedef struct packed {
      logic      frame_ok;
      byte_type  dist_blue;
      angle_type angle_blue;
      byte_type  dist_yellow;
      angle_type angle_yellow;
   } frame_result_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   byte_type  req_rx_byte = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_frame_ok;
   byte_type  rsp_dist_blue;
   angle_type rsp_angle_blue;
   byte_type  rsp_dist_yellow;
   angle_type rsp_angle_yellow;

   // Parser state kept by the testbench to predict each response.
   logic [2:0]       parse_phase = PHASE_HUNT;
   byte_type         crc_acc = CRC_INIT;
   byte_type         payload_bytes [PAYLOAD_LEN];
   frame_result_type held_values = '0;
   frame_result_type expected_frames [$];

   int  error_count = 0;
   int  idle_cycles = 0;
   bit  quiet_tail = 1'b0;

   camera_frame_receiver_crc8_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_dist_blue    (rsp_dist_blue),
      .rsp_angle_blue   (rsp_angle_blue),
      .rsp_dist_yellow  (rsp_dist_yellow),
      .rsp_angle_yellow (rsp_angle_yellow)
   );

   always #10 clock = ~clock;

   // CRC-8 over one byte, fed one data bit at a time from the MSB down.
   function automatic byte_type crc8_next(input byte_type crc, input byte_type data);
      byte_type r;
      logic     fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ data[i];
         r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   // Angle in degrees is twice the byte, folded back into -179..180.
   function automatic angle_type fold_angle(input byte_type b);
      int deg;
      deg = 2 * int'(b);
      if (deg > int'(ANGLE_HALF)) begin
         deg = deg - int'(ANGLE_FULL);
      end
      return angle_type'(deg);
   endfunction

   // Advance the predicted parser by one accepted byte; a check byte queues a response.
   function automatic void frame_parser_step(input byte_type b);
      frame_result_type       res;
      logic [2:0]             offset;
      logic [STORE_IDX_W-1:0] idx;
      offset = parse_phase - PHASE_PAY0;
      idx = offset[STORE_IDX_W-1:0];
      if (parse_phase >= PHASE_PAY0 && parse_phase <= PHASE_PAY3) begin
         payload_bytes[idx] = b;
         crc_acc = crc8_next(crc_acc, b);
         parse_phase = parse_phase + 3'd1;
      end else if (parse_phase == PHASE_CHECK) begin
         if (b == crc_acc) begin
            held_values.dist_blue    = payload_bytes[0];
            held_values.angle_blue   = fold_angle(payload_bytes[1]);
            held_values.dist_yellow  = payload_bytes[2];
            held_values.angle_yellow = fold_angle(payload_bytes[3]);
         end
         res = held_values;
         res.frame_ok = (b == crc_acc);
         expected_frames.push_back(res);
         parse_phase = PHASE_HUNT;
         crc_acc = CRC_INIT;
      end else begin
         // Hunting: only a start byte opens a frame.
         parse_phase = (b == START_BYTE) ? PHASE_PAY0 : PHASE_HUNT;
         crc_acc = CRC_INIT;
      end
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Track accepted requests through the predictor and check each response.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            frame_parser_step(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $error("response arrived with no frame pending");
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_ok", want.frame_ok, rsp_frame_ok);
               check_field("dist_blue", want.dist_blue, rsp_dist_blue);
               check_field("angle_blue", want.angle_blue, rsp_angle_blue);
               check_field("dist_yellow", want.dist_yellow, rsp_dist_yellow);
               check_field("angle_yellow", want.angle_yellow, rsp_angle_yellow);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Response back-pressure in random bursts, released for the quiet tail.
   initial begin
      @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offer one byte, possibly after an idle burst, and hold it until accepted.
   task automatic send_byte(input byte_type b);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   // Send start, payload and check byte; a nonzero flip corrupts the check byte.
   task automatic send_frame(input byte_type pay [PAYLOAD_LEN], input byte_type flip);
      byte_type crc;
      crc = CRC_INIT;
      send_byte(START_BYTE);
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         crc = crc8_next(crc, pay[i]);
         send_byte(pay[i]);
      end
      send_byte(crc ^ flip);
   endtask

   // Bytes other than the start byte are dropped while hunting.
   task automatic test_hunt_noise;
      send_byte(8'h00);
      send_byte(8'hFE);
      send_byte(8'h55);
      send_byte(8'hAA);
   endtask

   // A bad check byte right after reset reports the cleared held values.
   task automatic test_crc_mismatch;
      send_frame('{8'h01, 8'h02, 8'h03, 8'h04}, 8'h01);
   endtask

   // Angles at the fold boundary: 90 gives 180 and 91 gives -178.
   task automatic test_angle_wrap;
      send_frame('{8'h00, 8'h5A, 8'hFF, 8'h5B}, 8'h00);
   endtask

   // Start-byte values inside a frame are ordinary payload bytes.
   task automatic test_all_ones_frame;
      send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 8'h00);
   endtask

   // Mostly well-formed frames with random content, plus noise and broken frames.
   task automatic test_random_traffic;
      int       frame_bytes;
      int       kind;
      int       burst;
      byte_type pay [PAYLOAD_LEN];
      frame_bytes = 0;
      while (frame_bytes < RANDOM_BYTES) begin
         quiet_tail = (frame_bytes >= QUIET_FROM);
         kind = $urandom_range(0, 19);
         if (kind < 2) begin
            send_byte(byte_type'($urandom_range(0, 254)));
         end else if (kind < 3) begin
            burst = $urandom_range(1, 7);
            repeat (burst) send_byte(byte_type'($urandom_range(0, 255)));
            frame_bytes += burst;
         end else begin
            foreach (pay[i]) begin
               pay[i] = ($urandom_range(0, 7) == 0) ? START_BYTE
                                                    : byte_type'($urandom_range(0, 255));
            end
            send_frame(pay, (kind < 6) ? byte_type'($urandom_range(1, 255)) : 8'h00);
            frame_bytes += PAYLOAD_LEN + 2;
         end
      end
   endtask

   // Reset, run the tests in turn, then drain and report.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hunt_noise();
      test_crc_mismatch();
      test_angle_wrap();
      test_all_ones_frame();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/cfrc8_pkg.sv
src/camera_frame_receiver_crc8_top.sv
src/cfrc8_checker.sv
tb/camera_frame_receiver_crc8_top_test.sv
